// File: rtl/turing_machine_step_engine_defines.svh
// Assertion macros shared by the Turing machine step engine RTL.
`ifndef TURING_MACHINE_STEP_ENGINE_DEFINES_SVH
`define TURING_MACHINE_STEP_ENGINE_DEFINES_SVH

// Antecedent implies consequent in the same cycle.
`define TMSE_ASSERT_SAME(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Antecedent implies consequent in the next cycle.
`define TMSE_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// File: rtl/tmse_pkg.sv
// Package with constants and types of the Turing machine step engine.
package tmse_pkg;

	localparam int TAPE_CELLS  = 1024;
	localparam int MAX_SYMBOLS = 16;
	localparam int MAX_STATES  = 32;

	localparam int TAPE_AW    = $clog2(TAPE_CELLS);
	localparam int SYM_IW     = $clog2(MAX_SYMBOLS);
	localparam int ST_IW      = $clog2(MAX_STATES);
	localparam int SYM_CW     = $clog2(MAX_SYMBOLS + 1);
	localparam int ST_CW      = $clog2(MAX_STATES + 1);
	localparam int IDX_W      = (SYM_IW > ST_IW) ? SYM_IW : ST_IW;
	localparam int CNT_W      = (SYM_CW > ST_CW) ? SYM_CW : ST_CW;
	localparam int RULE_AW    = SYM_IW + ST_IW;
	localparam int RULE_DEPTH = MAX_SYMBOLS * MAX_STATES;
	localparam int RULE_W     = 18;
	localparam int CLR_DEPTH  = (TAPE_CELLS > RULE_DEPTH) ? TAPE_CELLS : RULE_DEPTH;
	localparam int CLR_W      = $clog2(CLR_DEPTH);
	localparam int HEAD_MID   = TAPE_CELLS / 2;

	localparam int CHAR_W   = 8;
	localparam int OFFSET_W = 10;
	localparam int HEAD_W   = 10;
	localparam int DIR_W    = 2;
	localparam int ERR_W    = 3;
	localparam int OP_W     = 3;

	localparam logic [OP_W-1:0] OP_INIT       = 3'd0;
	localparam logic [OP_W-1:0] OP_ADD_SYMBOL = 3'd1;
	localparam logic [OP_W-1:0] OP_ADD_STATE  = 3'd2;
	localparam logic [OP_W-1:0] OP_ADD_RULE   = 3'd3;
	localparam logic [OP_W-1:0] OP_WRITE      = 3'd4;
	localparam logic [OP_W-1:0] OP_READ       = 3'd5;
	localparam logic [OP_W-1:0] OP_SET_HEAD   = 3'd6;
	localparam logic [OP_W-1:0] OP_STEP       = 3'd7;

	localparam logic [ERR_W-1:0] ERR_OK     = 3'd0;
	localparam logic [ERR_W-1:0] ERR_SYMBOL = 3'd1;
	localparam logic [ERR_W-1:0] ERR_STATE  = 3'd2;
	localparam logic [ERR_W-1:0] ERR_FULL   = 3'd3;
	localparam logic [ERR_W-1:0] ERR_TAPE   = 3'd4;

	localparam logic [DIR_W-1:0] DIR_LEFT  = 2'd0;
	localparam logic [DIR_W-1:0] DIR_RIGHT = 2'd1;

	localparam logic       CFG_BLANK = 1'b0;
	localparam logic       CFG_STOP  = 1'b1;

	typedef struct packed {
		logic              clear;
		logic              add_sym;
		logic              add_st;
		logic [CHAR_W-1:0] data;
	} tmse_list_ctl_t;

	typedef struct packed {
		logic              start;
		logic              sel_state;
		logic [CHAR_W-1:0] key;
	} tmse_srch_req_t;

	typedef struct packed {
		logic             done;
		logic             found;
		logic [IDX_W-1:0] idx;
		logic             sym_full;
		logic             st_full;
	} tmse_srch_rsp_t;

endpackage

// File: rtl/tmse_ram.sv
// Generic single-write, single-read RAM with registered read data.
module tmse_ram #(
	parameter int DEPTH = 1024,
	parameter int WIDTH = 8
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end
endmodule

// File: rtl/tmse_lists.sv
// Symbol and state lists with a shared one-compare-per-cycle search unit.
module tmse_lists import tmse_pkg::*; (
	input  logic           clk,
	input  logic           arst_n,
	input  tmse_list_ctl_t ctl,
	input  tmse_srch_req_t req,
	output tmse_srch_rsp_t rsp
);
	logic [CHAR_W-1:0] sym_list [MAX_SYMBOLS];
	logic [CHAR_W-1:0] st_list  [MAX_STATES];
	logic [SYM_CW-1:0] sym_count_q;
	logic [ST_CW-1:0]  st_count_q;
	logic              busy_q;
	logic              sel_q;
	logic [CHAR_W-1:0] key_q;
	logic [CNT_W-1:0]  idx_q;
	logic [CNT_W-1:0]  cnt;
	logic [CHAR_W-1:0] entry;
	logic              at_end;
	logic              hit;

	assign cnt    = sel_q ? CNT_W'(st_count_q) : CNT_W'(sym_count_q);
	assign entry  = sel_q ? st_list[idx_q[ST_IW-1:0]] : sym_list[idx_q[SYM_IW-1:0]];
	assign at_end = idx_q >= cnt;
	assign hit    = entry == key_q;

	assign rsp.done     = busy_q && (at_end || hit);
	assign rsp.found    = busy_q && !at_end && hit;
	assign rsp.idx      = IDX_W'(idx_q);
	assign rsp.sym_full = 32'(sym_count_q) >= MAX_SYMBOLS;
	assign rsp.st_full  = 32'(st_count_q) >= MAX_STATES;

	always_ff @(posedge clk) begin
		if (ctl.add_sym && !rsp.sym_full) begin
			sym_list[sym_count_q[SYM_IW-1:0]] <= ctl.data;
		end
		if (ctl.add_st && !rsp.st_full) begin
			st_list[st_count_q[ST_IW-1:0]] <= ctl.data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sym_count_q <= '0;
			st_count_q  <= '0;
			busy_q      <= 1'b0;
			sel_q       <= 1'b0;
			key_q       <= '0;
			idx_q       <= '0;
		end else begin
			if (ctl.clear) begin
				sym_count_q <= '0;
				st_count_q  <= '0;
			end else begin
				if (ctl.add_sym && !rsp.sym_full) begin
					sym_count_q <= sym_count_q + 1'b1;
				end
				if (ctl.add_st && !rsp.st_full) begin
					st_count_q <= st_count_q + 1'b1;
				end
			end
			if (req.start) begin
				busy_q <= 1'b1;
				sel_q  <= req.sel_state;
				key_q  <= req.key;
				idx_q  <= '0;
			end else if (rsp.done) begin
				busy_q <= 1'b0;
			end else if (busy_q) begin
				idx_q <= idx_q + 1'b1;
			end
		end
	end
endmodule

// File: rtl/turing_machine_step_engine.sv
// Top level of the table-driven Turing machine step engine.
// One item is taken at a time, and in_stall stays high until its result is registered.
// Write, set head and list adds go through S_EXEC and S_OUT to that register, and a tape
// read goes first through S_TRD. Add rule runs both list searches before S_OUT, and a step
// reads the tape, runs both list searches and then reads the rule table. One comparator
// walks the lists and compares one entry per cycle (up to 16 symbols and 32 states).
// Init sweeps the tape and rule memories one address a cycle. A sweep that clears the rule
// table runs after reset before the first item is taken. A stalled result holds the
// engine until it is taken.
module turing_machine_step_engine import tmse_pkg::*; (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_stall,
	input  logic [OP_W-1:0]     operation,
	input  logic [CHAR_W-1:0]   symbol_char,
	input  logic [CHAR_W-1:0]   state_char,
	input  logic [CHAR_W-1:0]   match_symbol,
	input  logic [CHAR_W-1:0]   match_state,
	input  logic [DIR_W-1:0]    direction,
	input  logic [OFFSET_W-1:0] offset,
	output logic                out_valid,
	input  logic                out_stall,
	output logic [CHAR_W-1:0]   cell_symbol,
	output logic [HEAD_W-1:0]   head_position,
	output logic [CHAR_W-1:0]   current_state,
	output logic                halted,
	output logic [ERR_W-1:0]    error,
	input  logic                cfg_valid,
	output logic                cfg_ready,
	input  logic                cfg_index,
	input  logic [CHAR_W-1:0]   cfg_data
);
`include "turing_machine_step_engine_defines.svh"

	typedef enum logic [9:0] {
		S_CLR     = 10'b0000000001,
		S_IDLE    = 10'b0000000010,
		S_TRD     = 10'b0000000100,
		S_CELL    = 10'b0000001000,
		S_SSYM    = 10'b0000010000,
		S_SST     = 10'b0000100000,
		S_RULE_RD = 10'b0001000000,
		S_RULE    = 10'b0010000000,
		S_EXEC    = 10'b0100000000,
		S_OUT     = 10'b1000000000
	} tmse_state_t;

	tmse_state_t         st_q;
	logic [CLR_W-1:0]    clr_cnt_q;
	logic                clr_tape_q;
	logic                init_q;
	logic [CHAR_W-1:0]   blank_q;
	logic [CHAR_W-1:0]   stop_q;
	logic [TAPE_AW-1:0]  head_q;
	logic [CHAR_W-1:0]   mstate_q;
	logic [OP_W-1:0]     op_q;
	logic [CHAR_W-1:0]   sym_c_q;
	logic [CHAR_W-1:0]   st_c_q;
	logic [CHAR_W-1:0]   msym_q;
	logic [CHAR_W-1:0]   mst_q;
	logic [DIR_W-1:0]    dir_q;
	logic [OFFSET_W-1:0] off_q;
	logic [SYM_IW-1:0]   is_q;
	logic [ST_IW-1:0]    it_q;
	logic [CHAR_W-1:0]   rsym_q;
	logic [ERR_W-1:0]    err_q;
	logic                halt_q;
	logic                out_valid_q;

	logic                accept;
	logic                off_ok;
	logic                clr_last;
	logic                is_step;
	logic                tape_we;
	logic [TAPE_AW-1:0]  tape_waddr;
	logic [CHAR_W-1:0]   tape_wdata;
	logic [TAPE_AW-1:0]  tape_raddr;
	logic [CHAR_W-1:0]   tape_rdata;
	logic                rule_we;
	logic [RULE_AW-1:0]  rule_waddr;
	logic [RULE_W-1:0]   rule_wdata;
	logic [RULE_AW-1:0]  rule_raddr;
	logic [RULE_W-1:0]   rule_rdata;
	logic [CHAR_W-1:0]   r_sym;
	logic [CHAR_W-1:0]   r_next;
	logic [DIR_W-1:0]    r_dir;
	logic                r_halt;
	logic                r_off;
	tmse_list_ctl_t      lctl;
	tmse_srch_req_t      sreq;
	tmse_srch_rsp_t      srsp;

	assign accept    = in_valid && !in_stall;
	assign in_stall  = st_q != S_IDLE;
	assign cfg_ready = 1'b1;
	assign out_valid = out_valid_q;
	assign off_ok    = 32'(off_q) < TAPE_CELLS;
	assign clr_last  = 32'(clr_cnt_q) == CLR_DEPTH - 1;
	assign is_step   = op_q == OP_STEP;

	assign r_sym  = rule_rdata[RULE_W-1 -: CHAR_W];
	assign r_next = rule_rdata[DIR_W +: CHAR_W];
	assign r_dir  = rule_rdata[DIR_W-1:0];
	assign r_halt = r_next == stop_q;
	assign r_off  = (r_dir == DIR_LEFT && head_q == '0) ||
		(r_dir == DIR_RIGHT && 32'(head_q) == TAPE_CELLS - 1);

	tmse_ram #(.DEPTH(TAPE_CELLS), .WIDTH(CHAR_W)) u_tape (
		.clk   (clk),
		.we    (tape_we),
		.waddr (tape_waddr),
		.wdata (tape_wdata),
		.raddr (tape_raddr),
		.rdata (tape_rdata)
	);

	tmse_ram #(.DEPTH(RULE_DEPTH), .WIDTH(RULE_W)) u_rules (
		.clk   (clk),
		.we    (rule_we),
		.waddr (rule_waddr),
		.wdata (rule_wdata),
		.raddr (rule_raddr),
		.rdata (rule_rdata)
	);

	tmse_lists u_lists (
		.clk    (clk),
		.arst_n (arst_n),
		.ctl    (lctl),
		.req    (sreq),
		.rsp    (srsp)
	);

	always_comb begin
		tape_we    = 1'b0;
		tape_waddr = TAPE_AW'(clr_cnt_q);
		tape_wdata = blank_q;
		tape_raddr = (op_q == OP_READ) ? TAPE_AW'(off_q) : head_q;
		rule_we    = 1'b0;
		rule_waddr = RULE_AW'(clr_cnt_q);
		rule_wdata = '0;
		rule_raddr = {is_q, it_q};
		lctl.clear   = accept && operation == OP_INIT;
		lctl.add_sym = st_q == S_EXEC && op_q == OP_ADD_SYMBOL;
		lctl.add_st  = st_q == S_EXEC && op_q == OP_ADD_STATE;
		lctl.data    = (op_q == OP_ADD_STATE) ? st_c_q : sym_c_q;
		sreq.start     = 1'b0;
		sreq.sel_state = 1'b0;
		sreq.key       = is_step ? tape_rdata : msym_q;
		case (st_q)
			S_CLR: begin
				tape_we = clr_tape_q && 32'(clr_cnt_q) < TAPE_CELLS;
				rule_we = 32'(clr_cnt_q) < RULE_DEPTH;
			end
			S_CELL: begin
				sreq.start = 1'b1;
			end
			S_SSYM: begin
				sreq.sel_state = 1'b1;
				sreq.key       = is_step ? mstate_q : mst_q;
				sreq.start     = srsp.found;
			end
			S_SST: begin
				rule_we    = !is_step && srsp.found;
				rule_waddr = {is_q, srsp.idx[ST_IW-1:0]};
				rule_wdata = {sym_c_q, st_c_q, dir_q};
			end
			S_RULE: begin
				tape_we    = r_halt || !r_off;
				tape_waddr = head_q;
				tape_wdata = r_sym;
			end
			S_EXEC: begin
				tape_we    = op_q == OP_WRITE && off_ok;
				tape_waddr = TAPE_AW'(off_q);
				tape_wdata = sym_c_q;
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			op_q    <= operation;
			sym_c_q <= symbol_char;
			st_c_q  <= state_char;
			msym_q  <= match_symbol;
			mst_q   <= match_state;
			dir_q   <= direction;
			off_q   <= offset;
		end
		if (st_q == S_SSYM && srsp.found) begin
			is_q <= srsp.idx[SYM_IW-1:0];
		end
		if (st_q == S_SST && srsp.found) begin
			it_q <= srsp.idx[ST_IW-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q          <= S_CLR;
			clr_cnt_q     <= '0;
			clr_tape_q    <= 1'b0;
			init_q        <= 1'b0;
			blank_q       <= 8'd32;
			stop_q        <= '0;
			head_q        <= TAPE_AW'(HEAD_MID);
			mstate_q      <= '0;
			rsym_q        <= '0;
			err_q         <= ERR_OK;
			halt_q        <= 1'b0;
			out_valid_q   <= 1'b0;
			cell_symbol   <= '0;
			head_position <= '0;
			current_state <= '0;
			halted        <= 1'b0;
			error         <= ERR_OK;
		end else begin
			if (cfg_valid && cfg_ready) begin
				if (cfg_index == CFG_BLANK) begin
					blank_q <= cfg_data;
				end else begin
					stop_q <= cfg_data;
				end
			end
			if (out_valid_q && !out_stall && st_q != S_OUT) begin
				out_valid_q <= 1'b0;
			end
			case (st_q)
				S_CLR: begin
					clr_cnt_q <= clr_cnt_q + 1'b1;
					if (clr_last) begin
						st_q <= init_q ? S_OUT : S_IDLE;
					end
				end
				S_IDLE: begin
					if (accept) begin
						rsym_q <= '0;
						err_q  <= ERR_OK;
						halt_q <= 1'b0;
						case (operation)
							OP_INIT: begin
								st_q       <= S_CLR;
								clr_cnt_q  <= '0;
								clr_tape_q <= 1'b1;
								init_q     <= 1'b1;
								head_q     <= TAPE_AW'(HEAD_MID);
								mstate_q   <= state_char;
							end
							OP_ADD_RULE: st_q <= S_CELL;
							OP_READ, OP_STEP: st_q <= S_TRD;
							default: st_q <= S_EXEC;
						endcase
					end
				end
				S_TRD: begin
					st_q <= is_step ? S_CELL : S_EXEC;
				end
				S_CELL: begin
					if (is_step) begin
						rsym_q <= tape_rdata;
					end
					st_q <= S_SSYM;
				end
				S_SSYM: begin
					if (srsp.done) begin
						if (srsp.found) begin
							st_q <= S_SST;
						end else begin
							err_q <= ERR_SYMBOL;
							st_q  <= S_OUT;
						end
					end
				end
				S_SST: begin
					if (srsp.done) begin
						if (!srsp.found) begin
							err_q <= ERR_STATE;
							st_q  <= S_OUT;
						end else begin
							st_q <= is_step ? S_RULE_RD : S_OUT;
						end
					end
				end
				S_RULE_RD: begin
					st_q <= S_RULE;
				end
				S_RULE: begin
					if (r_halt) begin
						rsym_q <= r_sym;
						halt_q <= 1'b1;
					end else if (r_off) begin
						err_q <= ERR_TAPE;
					end else begin
						rsym_q   <= r_sym;
						mstate_q <= r_next;
						if (r_dir == DIR_LEFT) begin
							head_q <= head_q - 1'b1;
						end else if (r_dir == DIR_RIGHT) begin
							head_q <= head_q + 1'b1;
						end
					end
					st_q <= S_OUT;
				end
				S_EXEC: begin
					case (op_q)
						OP_ADD_SYMBOL: begin
							if (srsp.sym_full) begin
								err_q <= ERR_FULL;
							end
						end
						OP_ADD_STATE: begin
							if (srsp.st_full) begin
								err_q <= ERR_FULL;
							end
						end
						OP_WRITE: begin
							if (off_ok) begin
								rsym_q <= sym_c_q;
							end else begin
								err_q <= ERR_TAPE;
							end
						end
						OP_READ: begin
							if (off_ok) begin
								rsym_q <= tape_rdata;
							end else begin
								err_q <= ERR_TAPE;
							end
						end
						OP_SET_HEAD: begin
							if (off_ok) begin
								head_q <= TAPE_AW'(off_q);
							end else begin
								err_q <= ERR_TAPE;
							end
						end
						default: begin
						end
					endcase
					st_q <= S_OUT;
				end
				S_OUT: begin
					if (!out_valid_q || !out_stall) begin
						out_valid_q   <= 1'b1;
						cell_symbol   <= rsym_q;
						head_position <= HEAD_W'(head_q);
						current_state <= mstate_q;
						halted        <= halt_q;
						error         <= err_q;
						init_q        <= 1'b0;
						st_q          <= S_IDLE;
					end
				end
				default: begin
					st_q <= S_IDLE;
				end
			endcase
		end
	end

	`TMSE_ASSERT_NEXT(a_accept_busy, accept, st_q != S_IDLE, "item accepted but engine idle")
	`TMSE_ASSERT_SAME(a_search_owner, srsp.done, st_q == S_SSYM || st_q == S_SST,
		"search finished outside a search state")
	`TMSE_ASSERT_SAME(a_halt_clean, out_valid && halted, error == ERR_OK,
		"halted item carries an error")
endmodule

// File: dv/tb_turing_machine_step_engine.sv
// Self-checking testbench for the Turing machine step engine.
`timescale 1ns / 1ps

module tb_turing_machine_step_engine;
	import tmse_pkg::*;

	typedef struct {
		logic [OP_W-1:0]     op;
		logic [CHAR_W-1:0]   sym_c;
		logic [CHAR_W-1:0]   st_c;
		logic [CHAR_W-1:0]   m_sym;
		logic [CHAR_W-1:0]   m_st;
		logic [DIR_W-1:0]    dir;
		logic [OFFSET_W-1:0] off;
	} tm_item_t;

	typedef struct {
		logic [CHAR_W-1:0] sym;
		logic [HEAD_W-1:0] head;
		logic [CHAR_W-1:0] state;
		logic              halt;
		logic [ERR_W-1:0]  err;
	} tm_result_t;

	typedef struct {
		tm_item_t   item;
		bit         typed;
		tm_result_t res;
	} tm_row_t;

	localparam logic [HEAD_W-1:0] MID = HEAD_W'(HEAD_MID);

	logic                clk = 1'b0;
	logic                arst_n = 1'b0;
	logic                in_valid = 1'b0;
	logic                in_stall;
	logic [OP_W-1:0]     operation = '0;
	logic [CHAR_W-1:0]   symbol_char = '0;
	logic [CHAR_W-1:0]   state_char = '0;
	logic [CHAR_W-1:0]   match_symbol = '0;
	logic [CHAR_W-1:0]   match_state = '0;
	logic [DIR_W-1:0]    direction = '0;
	logic [OFFSET_W-1:0] offset = '0;
	logic                out_valid;
	logic                out_stall = 1'b0;
	logic [CHAR_W-1:0]   cell_symbol;
	logic [HEAD_W-1:0]   head_position;
	logic [CHAR_W-1:0]   current_state;
	logic                halted;
	logic [ERR_W-1:0]    error;
	logic                cfg_valid = 1'b0;
	logic                cfg_ready;
	logic                cfg_index = 1'b0;
	logic [CHAR_W-1:0]   cfg_data = '0;

	// Shadow machine state.
	logic [CHAR_W-1:0] tape_mem [TAPE_CELLS];
	logic [CHAR_W-1:0] rule_sym [RULE_DEPTH];
	logic [CHAR_W-1:0] rule_next [RULE_DEPTH];
	logic [DIR_W-1:0]  rule_dir [RULE_DEPTH];
	logic [CHAR_W-1:0] sym_list [MAX_SYMBOLS];
	logic [CHAR_W-1:0] st_list [MAX_STATES];
	int                sym_cnt = 0;
	int                st_cnt = 0;
	int                head_idx = HEAD_MID;
	logic [CHAR_W-1:0] mach_state = '0;
	logic [CHAR_W-1:0] blank_reg = 8'd32;
	logic [CHAR_W-1:0] stop_reg = 8'd0;

	tm_result_t expected_results[$];
	int         fail_count = 0;
	int         stall_left = 0;
	bit         quiet_out = 1'b0;
	bit         quiet_in = 1'b0;
	int         issued = 0;

	turing_machine_step_engine u_top (.*);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	function automatic int find_sym(logic [CHAR_W-1:0] v);
		for (int i = 0; i < sym_cnt; i++)
			if (sym_list[i] == v) return i;
		return -1;
	endfunction

	function automatic int find_state(logic [CHAR_W-1:0] v);
		for (int i = 0; i < st_cnt; i++)
			if (st_list[i] == v) return i;
		return -1;
	endfunction

	function automatic tm_result_t predict_result(tm_item_t it);
		tm_result_t r;
		int si, ti, h, ri;
		r.sym = '0;
		r.halt = 1'b0;
		r.err = ERR_OK;
		case (it.op)
			OP_INIT: begin
				sym_cnt = 0;
				st_cnt = 0;
				for (int i = 0; i < RULE_DEPTH; i++) begin
					rule_sym[i] = '0;
					rule_next[i] = '0;
					rule_dir[i] = '0;
				end
				for (int i = 0; i < TAPE_CELLS; i++) tape_mem[i] = blank_reg;
				head_idx = HEAD_MID;
				mach_state = it.st_c;
			end
			OP_ADD_SYMBOL: begin
				if (sym_cnt >= MAX_SYMBOLS) r.err = ERR_FULL;
				else sym_list[sym_cnt++] = it.sym_c;
			end
			OP_ADD_STATE: begin
				if (st_cnt >= MAX_STATES) r.err = ERR_FULL;
				else st_list[st_cnt++] = it.st_c;
			end
			OP_ADD_RULE: begin
				si = find_sym(it.m_sym);
				ti = find_state(it.m_st);
				if (si < 0) r.err = ERR_SYMBOL;
				else if (ti < 0) r.err = ERR_STATE;
				else begin
					ri = si * MAX_STATES + ti;
					rule_sym[ri] = it.sym_c;
					rule_next[ri] = it.st_c;
					rule_dir[ri] = it.dir;
				end
			end
			OP_WRITE: begin
				tape_mem[it.off] = it.sym_c;
				r.sym = it.sym_c;
			end
			OP_READ: r.sym = tape_mem[it.off];
			OP_SET_HEAD: head_idx = it.off;
			default: begin
				h = head_idx;
				r.sym = tape_mem[h];
				si = find_sym(tape_mem[h]);
				ti = find_state(mach_state);
				if (si < 0) r.err = ERR_SYMBOL;
				else if (ti < 0) r.err = ERR_STATE;
				else begin
					ri = si * MAX_STATES + ti;
					if (rule_next[ri] == stop_reg) begin
						tape_mem[h] = rule_sym[ri];
						r.sym = rule_sym[ri];
						r.halt = 1'b1;
					end else if (rule_dir[ri] == DIR_LEFT && h == 0) begin
						r.err = ERR_TAPE;
					end else if (rule_dir[ri] == DIR_RIGHT && h + 1 >= TAPE_CELLS) begin
						r.err = ERR_TAPE;
					end else begin
						tape_mem[h] = rule_sym[ri];
						r.sym = rule_sym[ri];
						mach_state = rule_next[ri];
						if (rule_dir[ri] == DIR_LEFT) head_idx = h - 1;
						else if (rule_dir[ri] == DIR_RIGHT) head_idx = h + 1;
					end
				end
			end
		endcase
		r.head = head_idx[HEAD_W-1:0];
		r.state = mach_state;
		return r;
	endfunction

	function automatic tm_item_t mk(logic [31:0] op, logic [31:0] sc, logic [31:0] stc,
			logic [31:0] ms, logic [31:0] mst, logic [31:0] dir, logic [31:0] off);
		tm_item_t it;
		it.op = op[OP_W-1:0];
		it.sym_c = sc[CHAR_W-1:0];
		it.st_c = stc[CHAR_W-1:0];
		it.m_sym = ms[CHAR_W-1:0];
		it.m_st = mst[CHAR_W-1:0];
		it.dir = dir[DIR_W-1:0];
		it.off = off[OFFSET_W-1:0];
		return it;
	endfunction

	function automatic tm_row_t row(tm_item_t it, bit typed, logic [7:0] esym,
			logic [9:0] ehead, logic [7:0] estate, logic ehalt, logic [2:0] eerr);
		tm_row_t rw;
		rw.item = it;
		rw.typed = typed;
		rw.res.sym = esym;
		rw.res.head = ehead;
		rw.res.state = estate;
		rw.res.halt = ehalt;
		rw.res.err = eerr;
		return rw;
	endfunction

	task automatic issue(tm_item_t it, bit typed, tm_result_t typed_res);
		tm_result_t p;
		int gap;
		if (issued % 40 == 0) quiet_in = ($urandom_range(0, 3) == 0);
		gap = quiet_in ? 0 : $urandom_range(0, 17);
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		p = predict_result(it);
		expected_results.push_back(typed ? typed_res : p);
		in_valid <= 1'b1;
		operation <= it.op;
		symbol_char <= it.sym_c;
		state_char <= it.st_c;
		match_symbol <= it.m_sym;
		match_state <= it.m_st;
		direction <= it.dir;
		offset <= it.off;
		@(posedge clk);
		while (in_stall) @(posedge clk);
		issued++;
	endtask

	task automatic send(tm_item_t it);
		tm_result_t none;
		none = '{default: '0};
		issue(it, 1'b0, none);
	endtask

	task automatic drain();
		in_valid <= 1'b0;
		while (expected_results.size() != 0) @(posedge clk);
		repeat (8) @(posedge clk);
	endtask

	task automatic write_reg(logic idx, logic [CHAR_W-1:0] val);
		drain();
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		cfg_valid <= 1'b0;
		if (idx == CFG_BLANK) blank_reg = val;
		else stop_reg = val;
	endtask

	task automatic run_phase(int n_steps, bit fill_lists);
		logic [CHAR_W-1:0] spool[$];
		logic [CHAR_W-1:0] tpool[$];
		logic [CHAR_W-1:0] v;
		int nsym, nst, r, h;
		tm_item_t it;
		nsym = fill_lists ? MAX_SYMBOLS + 1 : $urandom_range(2, 7);
		nst = fill_lists ? MAX_STATES + 1 : $urandom_range(2, 7);
		spool.push_back(blank_reg);
		tpool.push_back(CHAR_W'($urandom_range(0, 255)));
		for (int i = 1; i < nsym; i++) spool.push_back(CHAR_W'($urandom_range(0, 255)));
		for (int i = 1; i < nst; i++) tpool.push_back(CHAR_W'($urandom_range(0, 255)));
		send(mk(OP_INIT, $urandom, tpool[0], $urandom, $urandom, $urandom, $urandom));
		foreach (spool[i]) send(mk(OP_ADD_SYMBOL, spool[i], $urandom, $urandom, $urandom,
			$urandom, $urandom));
		foreach (tpool[i]) send(mk(OP_ADD_STATE, $urandom, tpool[i], $urandom, $urandom,
			$urandom, $urandom));
		if (fill_lists) begin
			spool = spool[0:4];
			tpool = tpool[0:4];
		end
		foreach (spool[i])
			foreach (tpool[j])
				if ($urandom_range(0, 4) != 0) begin
					v = ($urandom_range(0, 7) == 0) ? stop_reg :
						tpool[$urandom_range(0, tpool.size() - 1)];
					send(mk(OP_ADD_RULE, spool[$urandom_range(0, spool.size() - 1)], v,
						spool[i], tpool[j], $urandom_range(0, 3), $urandom));
				end
		for (int i = 0; i < 4; i++)
			send(mk(OP_WRITE, spool[$urandom_range(0, spool.size() - 1)], $urandom, $urandom,
				$urandom, $urandom, HEAD_MID - 2 + i));
		for (int n = 0; n < n_steps; n++) begin
			r = $urandom_range(0, 99);
			h = head_idx + $urandom_range(0, 6) - 3;
			if (h < 0) h = 0;
			if (h > TAPE_CELLS - 1) h = TAPE_CELLS - 1;
			if (r < 68) it = mk(OP_STEP, $urandom, $urandom, $urandom, $urandom, $urandom,
				$urandom);
			else if (r < 76) it = mk(OP_WRITE, spool[$urandom_range(0, spool.size() - 1)],
				$urandom, $urandom, $urandom, $urandom, h);
			else if (r < 81) it = mk(OP_SET_HEAD, $urandom, $urandom, $urandom, $urandom,
				$urandom, ($urandom_range(0, 1) ? 0 : TAPE_CELLS - 1) ^ $urandom_range(0, 1));
			else if (r < 87) it = mk(OP_ADD_RULE, spool[$urandom_range(0, spool.size() - 1)],
				tpool[$urandom_range(0, tpool.size() - 1)],
				spool[$urandom_range(0, spool.size() - 1)],
				tpool[$urandom_range(0, tpool.size() - 1)], $urandom, $urandom);
			else if (r < 92) it = mk(OP_READ, $urandom, $urandom, $urandom, $urandom, $urandom,
				$urandom);
			else begin
				it = mk($urandom_range(0, 7), $urandom, $urandom, $urandom, $urandom, $urandom,
					$urandom);
				if (it.op == OP_INIT && $urandom_range(0, 3) != 0) it.op = OP_STEP;
			end
			send(it);
		end
	endtask

	always @(posedge clk) begin
		tm_result_t e;
		if (out_valid && !out_stall) begin
			if (expected_results.size() == 0) begin
				$display("%0t: unexpected result: sym %0h head %0d state %0h halt %0b err %0d",
					$time, cell_symbol, head_position, current_state, halted, error);
				fail_count++;
			end else begin
				e = expected_results.pop_front();
				if (cell_symbol !== e.sym || head_position !== e.head ||
						current_state !== e.state || halted !== e.halt || error !== e.err) begin
					$display("%0t: expected sym %0h head %0d state %0h halt %0b err %0d",
						$time, e.sym, e.head, e.state, e.halt, e.err);
					$display("%0t: actual   sym %0h head %0d state %0h halt %0b err %0d",
						$time, cell_symbol, head_position, current_state, halted, error);
					fail_count++;
				end
			end
			if ($urandom_range(0, 29) == 0) quiet_out = !quiet_out;
			stall_left = quiet_out ? 0 : $urandom_range(0, 17);
			out_stall <= (stall_left != 0);
		end else if (stall_left > 0) begin
			stall_left--;
			out_stall <= (stall_left != 0);
		end
	end

	initial begin
		tm_row_t rows[$];
		rows.push_back(row(mk(OP_ADD_SYMBOL, 8'hFF, 0, 0, 0, 0, 0), 1, 0, MID, 0, 0, ERR_OK));
		rows.push_back(row(mk(OP_ADD_STATE, 0, 8'h00, 0, 0, 0, 0), 1, 0, MID, 0, 0, ERR_OK));
		rows.push_back(row(mk(OP_SET_HEAD, 0, 0, 0, 0, 0, 10'd1023), 1, 0, 10'd1023, 0, 0, ERR_OK));
		rows.push_back(row(mk(OP_SET_HEAD, 0, 0, 0, 0, 0, 10'd0), 1, 0, 10'd0, 0, 0, ERR_OK));
		rows.push_back(row(mk(OP_INIT, 0, 8'h05, 0, 0, 0, 0), 1, 0, MID, 8'h05, 0, ERR_OK));
		rows.push_back(row(mk(OP_READ, 0, 0, 0, 0, 0, 10'd0), 1, 8'd32, MID, 8'h05, 0, ERR_OK));
		rows.push_back(row(mk(OP_READ, 0, 0, 0, 0, 0, 10'd1023), 1, 8'd32, MID, 8'h05, 0,
			ERR_OK));
		rows.push_back(row(mk(OP_WRITE, 8'hAB, 0, 0, 0, 0, 10'd1023), 1, 8'hAB, MID, 8'h05, 0,
			ERR_OK));
		rows.push_back(row(mk(OP_STEP, 0, 0, 0, 0, 0, 0), 1, 8'd32, MID, 8'h05, 0, ERR_SYMBOL));
		rows.push_back(row(mk(OP_ADD_SYMBOL, 8'd32, 0, 0, 0, 0, 0), 0, 0, 0, 0, 0, 0));
		rows.push_back(row(mk(OP_STEP, 0, 0, 0, 0, 0, 0), 1, 8'd32, MID, 8'h05, 0, ERR_STATE));
		rows.push_back(row(mk(OP_ADD_RULE, 0, 0, 8'd32, 8'h05, 0, 0), 1, 0, MID, 8'h05, 0,
			ERR_STATE));
		rows.push_back(row(mk(OP_ADD_RULE, 0, 0, 8'h07, 8'h05, 0, 0), 1, 0, MID, 8'h05, 0,
			ERR_SYMBOL));
		rows.push_back(row(mk(OP_ADD_STATE, 0, 8'h05, 0, 0, 0, 0), 0, 0, 0, 0, 0, 0));
		// A rule that was never written names state zero, which is the stop state here.
		rows.push_back(row(mk(OP_STEP, 0, 0, 0, 0, 0, 0), 1, 8'd0, MID, 8'h05, 1, ERR_OK));
		rows.push_back(row(mk(OP_STEP, 0, 0, 0, 0, 0, 0), 1, 8'd0, MID, 8'h05, 0, ERR_SYMBOL));
		rows.push_back(row(mk(OP_ADD_SYMBOL, 8'h00, 0, 0, 0, 0, 0), 0, 0, 0, 0, 0, 0));
		rows.push_back(row(mk(OP_ADD_RULE, 8'h11, 8'h06, 8'd32, 8'h05, DIR_LEFT, 0), 0, 0, 0, 0, 0,
			0));
		rows.push_back(row(mk(OP_ADD_RULE, 8'hFF, 8'h05, 8'h00, 8'h05, DIR_RIGHT, 0), 0, 0, 0, 0, 0,
			0));
		rows.push_back(row(mk(OP_STEP, 0, 0, 0, 0, 0, 0), 0, 0, 0, 0, 0, 0));
		rows.push_back(row(mk(OP_SET_HEAD, 0, 0, 0, 0, 0, 10'd0), 1, 0, 10'd0, 8'h05, 0, ERR_OK));
		rows.push_back(row(mk(OP_STEP, 0, 0, 0, 0, 0, 0), 1, 8'd32, 10'd0, 8'h05, 0, ERR_TAPE));
		rows.push_back(row(mk(OP_SET_HEAD, 0, 0, 0, 0, 0, 10'd1023), 0, 0, 0, 0, 0, 0));
		rows.push_back(row(mk(OP_STEP, 0, 0, 0, 0, 3, 0), 0, 0, 0, 0, 0, 0));
		rows.push_back(row(mk(OP_STEP, 0, 0, 0, 0, 0, 0), 0, 0, 0, 0, 0, 0));

		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		foreach (rows[i]) issue(rows[i].item, rows[i].typed, rows[i].res);
		drain();

		write_reg(CFG_BLANK, 8'h00);
		write_reg(CFG_STOP, 8'hFF);
		run_phase(80, 1'b0);
		write_reg(CFG_BLANK, 8'hFF);
		write_reg(CFG_STOP, 8'h00);
		run_phase(60, 1'b1);
		write_reg(CFG_BLANK, CHAR_W'($urandom_range(0, 255)));
		write_reg(CFG_STOP, CHAR_W'($urandom_range(0, 255)));
		run_phase(90, 1'b0);
		write_reg(CFG_BLANK, 8'd32);
		write_reg(CFG_STOP, CHAR_W'($urandom_range(0, 255)));
		run_phase(90, 1'b0);

		drain();
		repeat (40) @(posedge clk);
		if (fail_count == 0 && expected_results.size() == 0) begin
			$display("SUCCESS");
		end else begin
			$display("FAILURE");
		end
		$finish;
	end

	initial begin
		#4_000_000;
		$display("FAILURE");
		$finish;
	end

endmodule
